// ----- rtl/acpp_pkg.sv -----
// Package for the ASCII coordinate packet parser.
// Holds the parser phase codes, character constants and per-byte helper functions.
// No dependencies.
package acpp_pkg;

    typedef logic [3:0] phase_t;

    // Parser phase codes
    localparam phase_t PH_HEADER = 4'd0;
    localparam phase_t PH_COMMA1 = 4'd1;
    localparam phase_t PH_X_PRE  = 4'd2;
    localparam phase_t PH_X_SIGN = 4'd3;
    localparam phase_t PH_X_DIG  = 4'd4;
    localparam phase_t PH_Y_PRE  = 4'd5;
    localparam phase_t PH_Y_SIGN = 4'd6;
    localparam phase_t PH_Y_DIG  = 4'd7;
    localparam phase_t PH_DONE   = 4'd8;
    localparam phase_t PH_FAIL   = 4'd9;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_HT    = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_S     = 8'h53;

    // scanf-style whitespace: space, HT, LF, VT, FF, CR
    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_HT) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // v*10 +/- digit, wrapping at 16 bits; c must be a decimal digit
    function automatic logic [15:0] accumulate(input logic [15:0] v,
                                               input logic [7:0]  c,
                                               input logic        neg);
        logic [15:0] times_ten;
        logic [15:0] digit;
        times_ten = {v[12:0], 3'b000} + {v[14:0], 1'b0};
        digit     = {12'h000, c[3:0]};
        return neg ? (times_ten - digit) : (times_ten + digit);
    endfunction

endpackage

// ----- rtl/ascii_coordinate_packet_parser.sv -----
// A line feed that ends a good packet passes through the input register and then the result register.
// Throughput: one byte per cycle while not stalled; the input register feeds the parser update and result register.
// The input side stalls only while a result is waiting and the next byte would produce another.
// Reset (rst_n low, asynchronous) clears the parser to expect a header byte and empties
// both the input and result registers.
// Depends on acpp_pkg.
module ascii_coordinate_packet_parser #(
    parameter int PACKET_BYTES = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] coord_x,
    output logic signed [15:0] coord_y
);
    import acpp_pkg::*;

    localparam int CNT_W = $clog2(PACKET_BYTES);
    localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(PACKET_BYTES - 1);

    // Input stage
    logic       stage_valid_reg;
    logic [7:0] byte_reg;

    // Parser state
    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      x_reg, x_next;
    logic [15:0]      y_reg, y_next;
    logic             minus_reg, minus_next;

    // Result register
    logic               out_valid_reg;
    logic signed [15:0] x_out_reg;
    logic signed [15:0] y_out_reg;

    // Parser view after a possible 'S' restart
    phase_t           base_phase;
    logic [CNT_W-1:0] base_count;
    logic [15:0]      base_x;
    logic [15:0]      base_y;
    logic             base_minus;
    logic             digit_go;
    logic             x_side;

    logic emit_hit;
    logic out_free;
    logic stage_adv;

    // Per-byte parser update
    always_comb
    begin
        if (byte_reg == CHAR_S)
        begin
            base_phase = PH_HEADER;
            base_count = '0;
            base_x     = '0;
            base_y     = '0;
            base_minus = 1'b0;
        end
        else
        begin
            base_phase = phase_reg;
            base_count = count_reg;
            base_x     = x_reg;
            base_y     = y_reg;
            base_minus = minus_reg;
        end

        phase_next = base_phase;
        count_next = base_count;
        x_next     = base_x;
        y_next     = base_y;
        minus_next = base_minus;
        digit_go   = 1'b0;
        x_side     = (base_phase == PH_X_PRE) || (base_phase == PH_X_SIGN);

        // bytes past the packet length limit are not parsed
        if (base_count < COUNT_LIMIT)
        begin
            count_next = base_count + 1'b1;
            if (byte_reg == CHAR_NUL)
            begin
                // NUL ends the text: good only once y digits were seen
                phase_next = ((base_phase == PH_Y_DIG) || (base_phase == PH_DONE))
                             ? PH_DONE : PH_FAIL;
            end
            else
            begin
                unique case (base_phase)
                    PH_HEADER:
                    begin
                        phase_next = (byte_reg == CHAR_S) ? PH_COMMA1 : PH_FAIL;
                    end
                    PH_COMMA1:
                    begin
                        phase_next = (byte_reg == CHAR_COMMA) ? PH_X_PRE : PH_FAIL;
                    end
                    PH_X_PRE, PH_Y_PRE:
                    begin
                        if (is_space(byte_reg))
                        begin
                            phase_next = base_phase;
                        end
                        else if ((byte_reg == CHAR_PLUS) || (byte_reg == CHAR_MINUS))
                        begin
                            minus_next = (byte_reg == CHAR_MINUS);
                            phase_next = x_side ? PH_X_SIGN : PH_Y_SIGN;
                        end
                        else
                        begin
                            minus_next = 1'b0;
                            digit_go   = 1'b1;
                        end
                    end
                    PH_X_SIGN, PH_Y_SIGN:
                    begin
                        digit_go = 1'b1;
                    end
                    PH_X_DIG:
                    begin
                        if (is_digit(byte_reg))
                        begin
                            x_next = accumulate(base_x, byte_reg, base_minus);
                        end
                        else if (byte_reg == CHAR_COMMA)
                        begin
                            phase_next = PH_Y_PRE;
                        end
                        else
                        begin
                            phase_next = PH_FAIL;
                        end
                    end
                    PH_Y_DIG:
                    begin
                        if (is_digit(byte_reg))
                        begin
                            y_next = accumulate(base_y, byte_reg, base_minus);
                        end
                        else
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_next = base_phase;
                    end
                endcase

                // first digit of an integer (mandatory after optional sign)
                if (digit_go)
                begin
                    if (!is_digit(byte_reg))
                    begin
                        phase_next = PH_FAIL;
                    end
                    else if (x_side)
                    begin
                        x_next     = accumulate(16'h0000, byte_reg, minus_next);
                        phase_next = PH_X_DIG;
                    end
                    else
                    begin
                        y_next     = accumulate(16'h0000, byte_reg, minus_next);
                        phase_next = PH_Y_DIG;
                    end
                end
            end
        end
    end

    // Handshake: the stage holds only when it has a result and the output is full
    assign emit_hit  = (byte_reg == CHAR_LF) &&
                       ((phase_next == PH_Y_DIG) || (phase_next == PH_DONE));
    assign out_free  = !out_valid_reg || out_ready;
    assign stage_adv = stage_valid_reg && (!emit_hit || out_free);
    assign in_ready  = !stage_valid_reg || stage_adv;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    // Parser state; a line feed restarts the packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            count_reg <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            minus_reg <= 1'b0;
        end
        else if (stage_adv)
        begin
            if (byte_reg == CHAR_LF)
            begin
                phase_reg <= PH_HEADER;
                count_reg <= '0;
                x_reg     <= '0;
                y_reg     <= '0;
                minus_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                x_reg     <= x_next;
                y_reg     <= y_next;
                minus_reg <= minus_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_adv && emit_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && emit_hit)
        begin
            x_out_reg <= $signed(x_next);
            y_out_reg <= $signed(y_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign coord_x   = x_out_reg;
    assign coord_y   = y_out_reg;

endmodule

// ----- rtl/acpp_checker.sv -----
// Port-level checker for the ASCII coordinate packet parser, plus its bind.
// Depends on acpp_pkg and on ascii_coordinate_packet_parser.
module acpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] coord_x,
    input logic [15:0] coord_y
);
    import acpp_pkg::*;

    logic lf_request;

    assign lf_request = in_valid && in_ready && (rx_byte == CHAR_LF);

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coord_x) && $stable(coord_y))
        else $error("result changed while stalled");

    // with the output empty the parser never back-pressures
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a new result always comes from a line feed request that passed through the input and result registers
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(lf_request, 2))
        else $error("result without a line feed request");

    // out of reset no result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result pending after reset");

endmodule

bind ascii_coordinate_packet_parser acpp_checker u_acpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coord_x   (coord_x),
    .coord_y   (coord_y)
);
